// ----- hdl/sem_pkg.sv -----
package sem_pkg;

  // field widths
  localparam int ANG_W  = 16;
  localparam int CLN_W  = 14;
  localparam int DEP_W  = 16;
  localparam int LEN_W  = 16;
  localparam int COST_W = 30;

  // depth continuity knees (4 fractional bits: 5 and 25 units)
  localparam int DEPTH_LO   = 80;
  localparam int DEPTH_HI   = 400;
  localparam int DEPTH_SPAN = DEPTH_HI - DEPTH_LO;

  // convexity ramp: 0.7 drop over pi/4 (pi/4 with 12 fractional bits)
  localparam int PI4_Q12    = 3217;
  localparam int CONV_SLOPE = 7;
  localparam int CONV_DEN   = 10 * PI4_Q12;

  // cleanliness is 12 fractional bits, saturated to +-1
  localparam int CLEAN_ONE = 4096;
  localparam int CLEAN_SH  = 13;

  localparam int COST_MAX = 1 << 28;

  // pipeline stages
  localparam int PIPE_STAGES = 8;
  localparam int ST_IN    = 0;
  localparam int ST_DIV_A = 1;
  localparam int ST_DIV_B = 2;
  localparam int ST_MIN   = 3;
  localparam int ST_NRM_A = 4;
  localparam int ST_NRM_B = 5;
  localparam int ST_SGN   = 6;
  localparam int ST_OUT   = 7;

  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;
    logic [PIPE_STAGES-1:0] vld;
  } sem_pipe_t;

endpackage

// ----- hdl/sem_rdiv.sv -----
// round(n * 2^SH / DEN), halves up, for a constant DEN.
// Reciprocal multiply gives a quotient that is low by at most one; the
// remainder taken in the second stage fixes it and applies the rounding.
module sem_rdiv #(
  parameter int NW  = 9,
  parameter int SH  = 12,
  parameter int DEN = 320,
  parameter int QW  = 12
) (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  logic [NW-1:0] n_i,
  output logic [QW-1:0] q_o
);

  localparam int KW = NW + SH;
  localparam longint unsigned MUL = (64'd1 << KW) / DEN;
  localparam int MW  = $clog2(MUL + 1);
  localparam int DW  = $clog2(DEN + 1);
  localparam int RW  = $clog2(3 * DEN);
  localparam int PW1 = NW + MW;
  localparam int PW2 = MW + DW;
  localparam logic [MW-1:0] MUL_C  = MUL[MW-1:0];
  localparam logic [DW-1:0] DEN_C  = DW'(DEN);
  localparam logic [RW-1:0] HALF_C = RW'(DEN / 2);
  localparam logic [RW-1:0] DEN1_C = RW'(DEN);
  localparam logic [RW-1:0] DEN2_C = RW'(2 * DEN);

  logic [PW1-1:0] prod_a;
  logic [MW-1:0]  q0_a_d, q0_a_q, q0_b_q;
  logic [NW-1:0]  n_a_q;
  logic [PW2-1:0] prod_b;
  logic [KW-1:0]  nsh;
  logic [RW-1:0]  rem_d, rem_q, rem_h;
  logic [MW:0]    q_rnd;

  assign prod_a = PW1'(n_i) * PW1'(MUL_C);
  assign q0_a_d = prod_a[PW1-1:NW];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q0_a_q <= q0_a_d;
      n_a_q  <= n_i;
    end
  end

  // remainder is below 2*DEN, so the low RW bits are enough
  assign prod_b = PW2'(q0_a_q) * PW2'(DEN_C);
  assign nsh    = KW'(n_a_q) << SH;
  assign rem_d  = nsh[RW-1:0] - prod_b[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q0_b_q <= q0_a_q;
      rem_q  <= rem_d;
    end
  end

  assign rem_h = rem_q + HALF_C;
  assign q_rnd = {1'b0, q0_b_q} + (MW+1)'(rem_h >= DEN1_C) + (MW+1)'(rem_h >= DEN2_C);
  assign q_o   = q_rnd[QW-1:0];

endmodule

// ----- hdl/sem_pipe_ctl.sv -----
// Stage valids and load enables. A stage loads when it is empty or when
// the stage after it moves, so bubbles are squeezed out under a stall.
module sem_pipe_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  output logic              valid_o,
  input  logic              stall_i,
  output sem_pkg::sem_pipe_t pipe_o
);

  import sem_pkg::*;

  localparam int NS = PIPE_STAGES;

  logic [NS-1:0] vld_q, vld_d, en;
  logic          in_acc, out_acc;

  always_comb begin
    en[NS-1] = ~vld_q[NS-1] | ~stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_d[0] = en[0] ? valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign stall_o = ~en[0];
  assign valid_o = vld_q[NS-1];
  assign pipe_o  = '{en: en, vld: vld_q};
  assign in_acc  = valid_i & ~stall_o;
  assign out_acc = valid_o & ~stall_i;

  // input only backs up when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&vld_q))
    else $error("input stalled with a free stage");

  // occupancy follows accepted and delivered transactions
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q))
                       + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("transaction lost or duplicated in pipeline");

endmodule

// ----- hdl/segment_edge_merge_cost.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   convexity_angle_i, cleanliness_i,
//                                                depth_step_i, boundary_length_i
// output    out        out_valid_o / out_stall_i edge_cost_o
//
// One edge per cycle sustained while out_stall_i is low; an accepted edge
// crosses 8 register stages (input register, two reciprocal-divide stages,
// min, two more divide stages, sign, multiply by boundary length) on its way to out_valid_o.
// Reset clears the stage valids only; payload registers are not reset.
// A stalled output holds; earlier stages keep filling until all 8 are full,
// and only then is in_stall_o raised.
module segment_edge_merge_cost #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [sem_pkg::ANG_W-1:0]  convexity_angle_i,
  input  logic signed [sem_pkg::CLN_W-1:0]  cleanliness_i,
  input  logic signed [sem_pkg::DEP_W-1:0]  depth_step_i,
  input  logic        [sem_pkg::LEN_W-1:0]  boundary_length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sem_pkg::COST_W-1:0] edge_cost_o
);

  import sem_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int ONE   = 1 << F;
  localparam int ALPHA = (8 * ONE + 5) / 10;
  localparam int DNW   = $clog2(DEPTH_SPAN);
  localparam int CNW   = $clog2(CONV_SLOPE * PI4_Q12 + 1);
  localparam int PCW   = CLN_W + 1 + F;
  localparam int PW    = F + 2 + LEN_W + 1;
  localparam int XW    = (PW > COST_W + 1) ? PW : COST_W + 1;
  localparam logic [F:0]          ONE_C   = (F+1)'(ONE);
  localparam logic signed [F+1:0] ALPHA_S = (F+2)'(ALPHA);

  sem_pipe_t pipe;

  sem_pipe_ctl u_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .pipe_o  (pipe)
  );

  // ---- input register
  logic signed [ANG_W-1:0] ang_q;
  logic signed [CLN_W-1:0] cln_q;
  logic signed [DEP_W-1:0] dep_q;
  logic [LEN_W-1:0]        len_q;

  always_ff @(posedge clk_i) begin
    if (pipe.en[ST_IN]) begin
      ang_q <= convexity_angle_i;
      cln_q <= cleanliness_i;
      dep_q <= depth_step_i;
      len_q <= boundary_length_i;
    end
  end

  // ---- plausibility numerators
  logic              lo_d, hi_d, neg_d;
  logic signed [DEP_W:0] dep_t;
  logic [DNW-1:0]    dep_n;
  logic signed [ANG_W:0] ang_abs;
  logic [11:0]       ang_c;
  logic [CNW-1:0]    conv_n;
  logic signed [CLN_W-1:0] cln_sat;
  logic signed [CLN_W:0]   cln_u;
  logic [PCW-1:0]    cln_wide;
  logic [F:0]        pcl_d;

  always_comb begin
    lo_d   = dep_q <= (DEP_W)'(DEPTH_LO);
    hi_d   = dep_q > (DEP_W)'(DEPTH_HI);
    dep_t  = (DEP_W+1)'(DEPTH_HI) - (DEP_W+1)'(dep_q);
    dep_n  = (!lo_d && !hi_d) ? dep_t[DNW-1:0] : '0;

    neg_d   = ang_q[ANG_W-1];
    ang_abs = -((ANG_W+1)'(ang_q));
    ang_c   = (ang_abs > (ANG_W+1)'(PI4_Q12)) ? 12'(PI4_Q12) : ang_abs[11:0];
    conv_n  = neg_d ? CNW'(ang_c) * CNW'(CONV_SLOPE) : '0;

    if (cln_q > (CLN_W)'(CLEAN_ONE)) begin
      cln_sat = (CLN_W)'(CLEAN_ONE);
    end else if (cln_q < -(CLN_W)'(CLEAN_ONE)) begin
      cln_sat = -(CLN_W)'(CLEAN_ONE);
    end else begin
      cln_sat = cln_q;
    end
    cln_u    = (CLN_W+1)'(cln_sat) + (CLN_W+1)'(CLEAN_ONE);
    cln_wide = (PCW'(cln_u[CLN_W-1:0]) << F) + PCW'(CLEAN_ONE);
    pcl_d    = cln_wide[CLEAN_SH +: F+1];
  end

  logic [F-1:0] q_dep, q_conv;

  sem_rdiv #(.NW(DNW), .SH(F), .DEN(DEPTH_SPAN), .QW(F)) u_div_dep (
    .clk_i (clk_i),
    .en_i  ({pipe.en[ST_DIV_B], pipe.en[ST_DIV_A]}),
    .n_i   (dep_n),
    .q_o   (q_dep)
  );

  sem_rdiv #(.NW(CNW), .SH(F), .DEN(CONV_DEN), .QW(F)) u_div_conv (
    .clk_i (clk_i),
    .en_i  ({pipe.en[ST_DIV_B], pipe.en[ST_DIV_A]}),
    .n_i   (conv_n),
    .q_o   (q_conv)
  );

  logic             s1_lo_q, s1_hi_q, s1_neg_q, s2_lo_q, s2_hi_q, s2_neg_q;
  logic [F:0]       s1_pcl_q, s2_pcl_q;
  logic [LEN_W-1:0] s1_len_q, s2_len_q;

  always_ff @(posedge clk_i) begin
    if (pipe.en[ST_DIV_A]) begin
      s1_lo_q  <= lo_d;
      s1_hi_q  <= hi_d;
      s1_neg_q <= neg_d;
      s1_pcl_q <= pcl_d;
      s1_len_q <= len_q;
    end
    if (pipe.en[ST_DIV_B]) begin
      s2_lo_q  <= s1_lo_q;
      s2_hi_q  <= s1_hi_q;
      s2_neg_q <= s1_neg_q;
      s2_pcl_q <= s1_pcl_q;
      s2_len_q <= s1_len_q;
    end
  end

  // ---- minimum and offset
  logic [F:0]          pcont, pconv, m_min;
  logic signed [F+1:0] d_off, d_mag;
  logic [F-1:0]        nd_d;

  always_comb begin
    if (s2_lo_q) begin
      pcont = ONE_C;
    end else if (s2_hi_q) begin
      pcont = '0;
    end else begin
      pcont = {1'b0, q_dep};
    end
    pconv = s2_neg_q ? ONE_C - {1'b0, q_conv} : ONE_C;
    m_min = (pconv < pcont) ? pconv : pcont;
    if (s2_pcl_q < m_min) begin
      m_min = s2_pcl_q;
    end
    d_off = $signed({1'b0, m_min}) - ALPHA_S;
    d_mag = d_off[F+1] ? -d_off : d_off;
    nd_d  = d_mag[F-1:0];
  end

  logic [F-1:0]     s3_nd_q;
  logic             s3_neg_q, s4_neg_q, s5_neg_q;
  logic [LEN_W-1:0] s3_len_q, s4_len_q, s5_len_q;

  always_ff @(posedge clk_i) begin
    if (pipe.en[ST_MIN]) begin
      s3_nd_q  <= nd_d;
      s3_neg_q <= d_off[F+1];
      s3_len_q <= s2_len_q;
    end
    if (pipe.en[ST_NRM_A]) begin
      s4_neg_q <= s3_neg_q;
      s4_len_q <= s3_len_q;
    end
    if (pipe.en[ST_NRM_B]) begin
      s5_neg_q <= s4_neg_q;
      s5_len_q <= s4_len_q;
    end
  end

  // ---- normalization, one divider per side of alpha
  logic [F:0] q_pos, q_neg;

  sem_rdiv #(.NW(F), .SH(F), .DEN(ONE - ALPHA), .QW(F+1)) u_div_pos (
    .clk_i (clk_i),
    .en_i  ({pipe.en[ST_NRM_B], pipe.en[ST_NRM_A]}),
    .n_i   (s3_nd_q),
    .q_o   (q_pos)
  );

  sem_rdiv #(.NW(F), .SH(F), .DEN(ALPHA), .QW(F+1)) u_div_neg (
    .clk_i (clk_i),
    .en_i  ({pipe.en[ST_NRM_B], pipe.en[ST_NRM_A]}),
    .n_i   (s3_nd_q),
    .q_o   (q_neg)
  );

  logic [F:0]          mag;
  logic signed [F+1:0] v_d, s6_v_q;
  logic [LEN_W-1:0]    s6_len_q;

  assign mag = s5_neg_q ? q_neg : q_pos;
  assign v_d = s5_neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk_i) begin
    if (pipe.en[ST_SGN]) begin
      s6_v_q   <= v_d;
      s6_len_q <= s5_len_q;
    end
  end

  // ---- scale by boundary length, saturate
  logic signed [PW-1:0]     prod;
  logic signed [XW-1:0]     prod_x, sat_x;
  logic signed [COST_W-1:0] cost_q;

  always_comb begin
    prod   = s6_v_q * $signed({1'b0, s6_len_q});
    prod_x = XW'(prod);
    if (prod_x > XW'(COST_MAX)) begin
      sat_x = XW'(COST_MAX);
    end else if (prod_x < -XW'(COST_MAX)) begin
      sat_x = -XW'(COST_MAX);
    end else begin
      sat_x = prod_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.en[ST_OUT]) begin
      cost_q <= sat_x[COST_W-1:0];
    end
  end

  assign edge_cost_o = cost_q;

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe.vld[ST_MIN] |-> (s3_neg_q ? (int'(s3_nd_q) <= ALPHA)
                                   : (int'(s3_nd_q) <= ONE - ALPHA)))
    else $error("offset from alpha out of range");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe.vld[ST_SGN] |-> (s6_v_q <= (F+2)'(ONE) && s6_v_q >= -(F+2)'(ONE)))
    else $error("normalized cost outside [-1,1]");

endmodule
